[rtl/hyperloglog_sketch_core_defines.svh]
// ---------------------------------------------------------------------------
// HyperLogLog sketch core assertion macros
// Shared assertion forms, sampled on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef HYPERLOGLOG_SKETCH_CORE_DEFINES_SVH
`define HYPERLOGLOG_SKETCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define HSK_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hyperloglog_sketch_core: assertion failed");

// Next-cycle implication.
`define HSK_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hyperloglog_sketch_core: assertion failed");

`endif

[rtl/hsk_pkg.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch package
// Constants, codes and the command type shared by the sketch modules.
// ---------------------------------------------------------------------------
`default_nettype none

package hsk_pkg;

   localparam int INDEX_BITS_DEFAULT      = 14;
   localparam int KEY_LENGTH_BITS_DEFAULT = 16;
   localparam int MAX_INDEX_BITS          = 16;
   localparam int RANK_BITS               = 5;
   localparam int EST_BITS                = 40;

   localparam logic [31:0] MM_SEED = 32'h1BAD_B002;
   localparam logic [31:0] MM_MUL  = 32'h5BD1_E995;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_COUNT = 1'b1;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [MAX_INDEX_BITS-1:0] index;
      logic [RANK_BITS-1:0]      rank;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/hsk_ram.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hsk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[rtl/hsk_queue.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch command queue
// Two-entry queue that decouples the hashing front from the register back.
// ---------------------------------------------------------------------------
`default_nettype none

module hsk_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[rtl/hsk_front.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch front end
// Accepts transactions, runs the MurmurHash2 mixing and queues commands.
// ---------------------------------------------------------------------------
`default_nettype none

module hsk_front #(
   parameter int INDEX_BITS      = hsk_pkg::INDEX_BITS_DEFAULT,
   parameter int KEY_LENGTH_BITS = hsk_pkg::KEY_LENGTH_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_func,
   input  wire logic [31:0]      req_key_word,
   input  wire logic [15:0]      req_key_length,
   input  wire logic             req_last_word,
   input  wire logic             clearing,
   input  wire logic             q_full,
   output logic                  q_push,
   output hsk_pkg::cmd_type      q_cmd
);

   localparam int KLB = KEY_LENGTH_BITS;

   typedef enum logic [1:0] {F_IDLE, F_MIX, F_FIN1, F_FIN2} state_type;

   state_type      state_ff, state_in;
   logic [31:0]    h_ff, h_in;
   logic [31:0]    kmul_ff, kmul_in, hmul_ff, hmul_in, fmul_ff, fmul_in;
   logic [KLB-1:0] consumed_ff, consumed_in, total_ff, total_in;
   logic           inprog_ff, inprog_in, last_ff, last_in;

   logic           accept;
   logic [KLB+15:0] klen_ext;
   logic [KLB+31:0] total_ext;
   logic [KLB-1:0] total_cur, cons_cur, rem;
   logic [31:0]    h_cur, tail_mask, kmix, h2;

   function automatic logic [hsk_pkg::RANK_BITS-1:0] rank_of(input logic [31:0] h);
      logic [hsk_pkg::RANK_BITS-1:0] r;
      r = hsk_pkg::RANK_BITS'(33 - INDEX_BITS);
      for (int i = INDEX_BITS; i < 32; i++) begin
         if (h[i]) begin
            r = hsk_pkg::RANK_BITS'(32 - i);
         end
      end
      return r;
   endfunction

   assign req_stall = (state_ff != F_IDLE) || q_full || clearing;
   assign accept    = req_valid && !req_stall;
   assign klen_ext  = {{KLB{1'b0}}, req_key_length};
   assign total_cur = inprog_ff ? total_ff : klen_ext[KLB-1:0];
   assign cons_cur  = inprog_ff ? consumed_ff : '0;
   assign total_ext = {32'd0, total_cur};
   assign h_cur     = inprog_ff ? h_ff : (hsk_pkg::MM_SEED ^ total_ext[31:0]);
   assign rem       = total_cur - cons_cur;
   assign kmix      = kmul_ff ^ (kmul_ff >> 24);
   assign h2        = fmul_ff ^ (fmul_ff >> 15);

   always_comb begin
      case (rem[1:0])
         2'd1:    tail_mask = 32'h0000_00FF;
         2'd2:    tail_mask = 32'h0000_FFFF;
         2'd3:    tail_mask = 32'h00FF_FFFF;
         default: tail_mask = 32'h0000_0000;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      kmul_in     = kmul_ff;
      hmul_in     = hmul_ff;
      fmul_in     = fmul_ff;
      consumed_in = consumed_ff;
      total_in    = total_ff;
      inprog_in   = inprog_ff;
      last_in     = last_ff;
      q_push      = 1'b0;
      q_cmd       = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept && req_func == hsk_pkg::FUNC_COUNT) begin
               q_push     = 1'b1;
               q_cmd.kind = hsk_pkg::KIND_COUNT;
            end else if (accept) begin
               total_in  = total_cur;
               inprog_in = !req_last_word;
               last_in   = req_last_word;
               if (rem >= KLB'(4)) begin
                  kmul_in     = req_key_word * hsk_pkg::MM_MUL;
                  hmul_in     = h_cur * hsk_pkg::MM_MUL;
                  consumed_in = cons_cur + KLB'(4);
                  state_in    = F_MIX;
               end else begin
                  if (rem != '0) begin
                     h_in        = (h_cur ^ (req_key_word & tail_mask)) * hsk_pkg::MM_MUL;
                     consumed_in = total_cur;
                  end else begin
                     h_in        = h_cur;
                     consumed_in = cons_cur;
                  end
                  state_in = req_last_word ? F_FIN1 : F_IDLE;
               end
            end
         end
         F_MIX: begin
            h_in     = hmul_ff ^ (kmix * hsk_pkg::MM_MUL);
            state_in = last_ff ? F_FIN1 : F_IDLE;
         end
         F_FIN1: begin
            fmul_in  = (h_ff ^ (h_ff >> 13)) * hsk_pkg::MM_MUL;
            state_in = F_FIN2;
         end
         F_FIN2: begin
            if (!q_full) begin
               q_push                     = 1'b1;
               q_cmd.kind                 = hsk_pkg::KIND_ADD;
               q_cmd.index[INDEX_BITS-1:0] = h2[INDEX_BITS-1:0];
               q_cmd.rank                 = rank_of(h2);
               state_in                   = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         h_ff        <= '0;
         consumed_ff <= '0;
         total_ff    <= '0;
         inprog_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         h_ff        <= h_in;
         consumed_ff <= consumed_in;
         total_ff    <= total_in;
         inprog_ff   <= inprog_in;
      end
      kmul_ff <= kmul_in;
      hmul_ff <= hmul_in;
      fmul_ff <= fmul_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

[rtl/hsk_back.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch back end
// Updates rank registers, walks them for estimates and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module hsk_back #(
   parameter int INDEX_BITS = hsk_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire hsk_pkg::cmd_type             q_cmd,
   input  wire logic                         q_empty,
   output logic                              q_pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_result_kind,
   output logic                              rsp_register_raised,
   output logic [INDEX_BITS-1:0]             rsp_register_index,
   output logic [hsk_pkg::EST_BITS-1:0]      rsp_estimate
);

   localparam int RB = hsk_pkg::RANK_BITS;
   localparam int EB = hsk_pkg::EST_BITS;
   localparam int SW = INDEX_BITS + 33;
   localparam int CW = INDEX_BITS + 1;
   localparam longint unsigned M         = 64'd1 << INDEX_BITS;
   localparam longint unsigned ALPHA_NUM = 64'd7213 * (64'd1 << 30) * M;
   localparam longint unsigned ALPHA_DEN = 64'd10 * (64'd1000 * M + 64'd1079);
   localparam longint unsigned ALPHA_Q   = (ALPHA_NUM + ALPHA_DEN / 2) / ALPHA_DEN;
   localparam logic [63:0] DIVIDEND  = 64'(ALPHA_Q << (2 + 2 * INDEX_BITS));
   localparam logic [63:0] LIN_LHS   = 64'(ALPHA_Q << (3 + INDEX_BITS));
   localparam logic [63:0] LN2_Q30   = 64'd744261118;
   localparam logic [63:0] EST_MAX   = (64'd1 << EB) - 64'd1;
   localparam logic [34:0] TOP_LOG   = 35'(INDEX_BITS) << 30;
   localparam int          EST_SHIFT = 60 - INDEX_BITS;
   localparam logic [6:0]  DIV_LAST  = 7'd63;
   localparam logic [6:0]  SQR_LAST  = 7'd29;
   localparam logic [6:0]  MUL_LAST  = 7'd34;
   localparam logic [6:0]  NORM_TOP  = 7'd30;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ADD, S_WALK, S_DIV, S_NORM, S_SQR, S_MUL
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in, zeros_ff, zeros_in;
   logic                   rd_v_ff, rd_v_in;
   logic [SW-1:0]          sum_ff, sum_in, rem_ff, rem_in;
   logic [63:0]            dq_ff, dq_in, acc_ff, acc_in, mc_ff, mc_in;
   logic [6:0]             step_ff, step_in;
   logic [31:0]            y_ff, y_in;
   logic [4:0]             k_ff, k_in;
   logic [29:0]            frac_ff, frac_in;
   logic [34:0]            td_ff, td_in;
   hsk_pkg::cmd_type       cmd_ff, cmd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   kind_ff, kind_in, raised_ff, raised_in;
   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic [EB-1:0]          est_ff, est_in;

   logic                   we;
   logic [INDEX_BITS-1:0]  waddr, raddr;
   logic [RB-1:0]          wdata, rdata;
   logic [32:0]            term;
   logic [SW+2:0]          sum5;
   logic [SW:0]            rem_t;
   logic                   ge;
   logic [63:0]            prod, est_wide;
   logic [31:0]            ps;

   function automatic logic [EB-1:0] sat(input logic [63:0] v);
      return (v > EST_MAX) ? EST_MAX[EB-1:0] : v[EB-1:0];
   endfunction

   hsk_ram #(.WIDTH(RB), .DEPTH(1 << INDEX_BITS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign clearing            = (state_ff == S_CLEAR);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_register_raised = raised_ff;
   assign rsp_register_index  = index_ff;
   assign rsp_estimate        = est_ff;

   assign term  = 33'd1 << (6'd32 - {1'b0, rdata});
   assign sum5  = {1'b0, sum_ff, 2'b00} + {3'b000, sum_ff};
   assign rem_t = {rem_ff, dq_ff[63]};
   assign ge    = (rem_t >= {1'b0, sum_ff});
   assign prod  = y_ff * y_ff;
   assign ps    = prod[61:30];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      zeros_in     = zeros_ff;
      rd_v_in      = 1'b0;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      acc_in       = acc_ff;
      mc_in        = mc_ff;
      step_in      = step_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      td_in        = td_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      raised_in    = raised_ff;
      index_in     = index_ff;
      est_in       = est_ff;
      est_wide     = '0;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = cmd_ff.index[INDEX_BITS-1:0];
      wdata        = cmd_ff.rank;
      raddr        = q_cmd.index[INDEX_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            waddr  = cnt_ff[INDEX_BITS-1:0];
            wdata  = '0;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff[INDEX_BITS-1:0] == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!rsp_valid_ff && !q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.kind == hsk_pkg::KIND_ADD) begin
                  state_in = S_ADD;
               end else begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  zeros_in = '0;
                  state_in = S_WALK;
               end
            end
         end
         S_ADD: begin
            rsp_valid_in = 1'b1;
            kind_in      = hsk_pkg::KIND_ADD;
            raised_in    = (cmd_ff.rank > rdata);
            index_in     = cmd_ff.index[INDEX_BITS-1:0];
            est_in       = '0;
            we           = (cmd_ff.rank > rdata);
            state_in     = S_IDLE;
         end
         S_WALK: begin
            raddr = cnt_ff[INDEX_BITS-1:0];
            if (!cnt_ff[INDEX_BITS]) begin
               cnt_in  = cnt_ff + CW'(1);
               rd_v_in = 1'b1;
            end
            if (rd_v_ff) begin
               sum_in = sum_ff + SW'(term);
               if (rdata == '0) begin
                  zeros_in = zeros_ff + CW'(1);
               end
            end
            if (cnt_ff[INDEX_BITS] && !rd_v_ff) begin
               step_in = '0;
               if ((LIN_LHS < 64'(sum5)) && (zeros_ff != '0)) begin
                  y_in     = 32'(zeros_ff);
                  state_in = S_NORM;
               end else begin
                  rem_in   = '0;
                  dq_in    = DIVIDEND;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in  = ge ? SW'(rem_t - {1'b0, sum_ff}) : rem_t[SW-1:0];
            dq_in   = {dq_ff[62:0], ge};
            step_in = step_ff + 7'd1;
            if (step_ff == DIV_LAST) begin
               rsp_valid_in = 1'b1;
               kind_in      = hsk_pkg::KIND_COUNT;
               raised_in    = 1'b0;
               index_in     = '0;
               est_in       = sat(dq_in);
               state_in     = S_IDLE;
            end
         end
         S_NORM: begin
            if (!y_ff[30]) begin
               y_in    = {y_ff[30:0], 1'b0};
               step_in = step_ff + 7'd1;
            end else begin
               k_in     = 5'(NORM_TOP - step_ff);
               frac_in  = '0;
               step_in  = '0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            y_in    = ps[31] ? {1'b0, ps[31:1]} : ps;
            frac_in = {frac_ff[28:0], ps[31]};
            step_in = step_ff + 7'd1;
            if (step_ff == SQR_LAST) begin
               td_in    = TOP_LOG - {k_ff, frac_in};
               acc_in   = '0;
               mc_in    = LN2_Q30;
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (td_ff[0]) begin
               acc_in = acc_ff + mc_ff;
            end
            td_in   = {1'b0, td_ff[34:1]};
            mc_in   = {mc_ff[62:0], 1'b0};
            step_in = step_ff + 7'd1;
            if (step_ff == MUL_LAST) begin
               est_wide     = acc_in >> EST_SHIFT;
               rsp_valid_in = 1'b1;
               kind_in      = hsk_pkg::KIND_COUNT;
               raised_in    = 1'b0;
               index_in     = '0;
               est_in       = sat(est_wide);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zeros_ff  <= zeros_in;
      sum_ff    <= sum_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      acc_ff    <= acc_in;
      mc_ff     <= mc_in;
      step_ff   <= step_in;
      y_ff      <= y_in;
      k_ff      <= k_in;
      frac_ff   <= frac_in;
      td_ff     <= td_in;
      cmd_ff    <= cmd_in;
      kind_ff   <= kind_in;
      raised_ff <= raised_in;
      index_ff  <= index_in;
      est_ff    <= est_in;
   end

endmodule

`default_nettype wire

[rtl/hyperloglog_sketch_core.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch core
// Cardinality sketch over MurmurHash2 keys with 2^INDEX_BITS rank registers.
// ---------------------------------------------------------------------------
// Usage: keys enter on the req_ channel as little-endian 32-bit words with
// req_func add; req_key_length is taken from the first word of a key and
// req_last_word closes it. A count transaction (req_func count) returns the
// cardinality estimate. Each closed key and each count gives one rsp_
// transaction; other words give none.
// Flow: a full key word passes through the front's mix state (two dependent
// 32-bit multiplies), a tail or empty word is handled in the idle state, and
// a closing word passes through both finalizer states before its command is
// queued. The back handles an add as a rank read, a compare and write, and a
// result. A count walks all 2^INDEX_BITS registers through the RAM read
// port, then runs a 64-step divider, or in the linear-counting case up to
// 30 normalize, 30 squaring and 35 multiply steps.
// Reset: a clearing pass writes zero to every one of the 2^INDEX_BITS rank
// registers (16384 by default), with req_stall high.
// Stalls: a result waits in the output register while rsp_stall is high;
// the front stalls while busy with a word, while clearing, or while the two-entry command queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module hyperloglog_sketch_core #(
   parameter int INDEX_BITS      = hsk_pkg::INDEX_BITS_DEFAULT,
   parameter int KEY_LENGTH_BITS = hsk_pkg::KEY_LENGTH_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_func,
   input  wire logic [31:0]                  req_key_word,
   input  wire logic [15:0]                  req_key_length,
   input  wire logic                         req_last_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_result_kind,
   output logic                              rsp_register_raised,
   output logic [INDEX_BITS-1:0]             rsp_register_index,
   output logic [hsk_pkg::EST_BITS-1:0]      rsp_estimate
);

   localparam int CMD_W = $bits(hsk_pkg::cmd_type);

   hsk_pkg::cmd_type push_cmd, pop_cmd;
   logic [CMD_W-1:0] pop_bits;
   logic             q_push, q_pop, q_full, q_empty, clearing;

   assign pop_cmd = hsk_pkg::cmd_type'(pop_bits);

   hsk_front #(.INDEX_BITS(INDEX_BITS), .KEY_LENGTH_BITS(KEY_LENGTH_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_key_word   (req_key_word),
      .req_key_length (req_key_length),
      .req_last_word  (req_last_word),
      .clearing       (clearing),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   hsk_queue #(.WIDTH(CMD_W)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (push_cmd),
      .pop   (q_pop),
      .rdata (pop_bits),
      .full  (q_full),
      .empty (q_empty)
   );

   hsk_back #(.INDEX_BITS(INDEX_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_cmd               (pop_cmd),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_register_raised (rsp_register_raised),
      .rsp_register_index  (rsp_register_index),
      .rsp_estimate        (rsp_estimate)
   );

endmodule

`default_nettype wire

[rtl/hsk_checker.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch port checker
// Watches the top-level ports of the sketch core over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hyperloglog_sketch_core_defines.svh"

module hsk_checker #(
   parameter int INDEX_BITS = hsk_pkg::INDEX_BITS_DEFAULT
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_result_kind,
   input wire logic                         rsp_register_raised,
   input wire logic [INDEX_BITS-1:0]        rsp_register_index,
   input wire logic [hsk_pkg::EST_BITS-1:0] rsp_estimate
);

   `HSK_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_estimate) && $stable(rsp_register_index) && $stable(rsp_result_kind))
   `HSK_ASSERT_IMP(a_count_fields, rsp_valid && rsp_result_kind == hsk_pkg::KIND_COUNT, !rsp_register_raised && rsp_register_index == '0)
   `HSK_ASSERT_IMP(a_add_fields, rsp_valid && rsp_result_kind == hsk_pkg::KIND_ADD, rsp_estimate == '0)
   `HSK_ASSERT_IMP(a_clear_after_reset, $past(reset), req_stall && !rsp_valid)

endmodule

bind hyperloglog_sketch_core hsk_checker #(.INDEX_BITS(INDEX_BITS)) u_hsk_checker (.*);

`default_nettype wire

[tb/hyperloglog_sketch_core_test.sv]
// ---------------------------------------------------------------------------
// HyperLogLog sketch core testbench
// Streams keys of assorted lengths and count queries into the sketch, keeps
// its own copy of the rank registers and hash state, and compares every
// result field with the expected value under random gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module hyperloglog_sketch_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_BITS = hsk_pkg::INDEX_BITS_DEFAULT;
   localparam int NUM_REGS = 1 << IDX_BITS;
   localparam longint unsigned EST_LIMIT = (64'd1 << 40) - 64'd1;
   localparam longint unsigned LN2_FIXED = 64'd744261118;
   localparam int IDLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = hsk_pkg::FUNC_ADD;
   logic [31:0] req_key_word = '0;
   logic [15:0] req_key_length = '0;
   logic req_last_word = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic rsp_register_raised;
   logic [IDX_BITS-1:0] rsp_register_index;
   logic [hsk_pkg::EST_BITS-1:0] rsp_estimate;

   typedef struct packed {
      logic kind;
      logic raised;
      logic [IDX_BITS-1:0] index;
      logic [hsk_pkg::EST_BITS-1:0] estimate;
   } sketch_result_type;

   sketch_result_type pending_results[$];
   logic [4:0] rank_copy[NUM_REGS];
   logic [31:0] hash_state;
   logic [31:0] bytes_mixed;
   logic [31:0] key_bytes;
   logic key_open;
   int mismatches = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit failed = 1'b0;

   hyperloglog_sketch_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_key_word(req_key_word), .req_key_length(req_key_length),
      .req_last_word(req_last_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_register_raised(rsp_register_raised),
      .rsp_register_index(rsp_register_index), .rsp_estimate(rsp_estimate)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int bit_count_len(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         v = v >> 1;
         n++;
      end
      return n;
   endfunction

   function automatic longint unsigned log2_fixed(int unsigned z);
      int k;
      longint unsigned y;
      longint unsigned frac;
      k = bit_count_len(z) - 1;
      y = longint'(z) << (30 - k);
      frac = 0;
      for (int i = 1; i <= 30; i++) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            frac |= 64'd1 << (30 - i);
         end
      end
      return (longint'(k) << 30) | frac;
   endfunction

   function automatic longint unsigned cardinality_estimate();
      longint unsigned m, s, num, den, alpha_q, est, t;
      int unsigned zeros;
      m = NUM_REGS;
      s = 0;
      zeros = 0;
      for (int i = 0; i < NUM_REGS; i++) begin
         s += 64'd1 << (32 - rank_copy[i]);
         if (rank_copy[i] == 0) zeros++;
      end
      num = 64'd7213 * (64'd1 << 30) * m;
      den = 64'd10 * (64'd1000 * m + 64'd1079);
      alpha_q = (num + den / 2) / den;
      est = (alpha_q << (2 + 2 * IDX_BITS)) / s;
      if (8 * alpha_q * m < 5 * s && zeros != 0) begin
         t = (longint'(IDX_BITS) << 30) - log2_fixed(zeros);
         t = t * LN2_FIXED;
         est = t >> (60 - IDX_BITS);
      end
      return (est > EST_LIMIT) ? EST_LIMIT : est;
   endfunction

   task automatic predict_sketch(input logic func, input logic [31:0] word,
                                 input logic [15:0] klen, input logic last);
      sketch_result_type r;
      logic [31:0] h, k, rem, val;
      int rank;
      r = '0;
      if (func == hsk_pkg::FUNC_COUNT) begin
         r.kind = hsk_pkg::KIND_COUNT;
         r.estimate = cardinality_estimate();
         pending_results.push_back(r);
         return;
      end
      if (!key_open) begin
         key_bytes = {16'd0, klen};
         bytes_mixed = 0;
         hash_state = hsk_pkg::MM_SEED ^ key_bytes;
      end
      h = hash_state;
      rem = key_bytes - bytes_mixed;
      if (rem >= 4) begin
         k = word * hsk_pkg::MM_MUL;
         k ^= k >> 24;
         k = k * hsk_pkg::MM_MUL;
         h = h * hsk_pkg::MM_MUL;
         h ^= k;
         bytes_mixed += 4;
      end else if (rem > 0) begin
         h ^= word & ((32'd1 << (8 * rem)) - 1);
         h = h * hsk_pkg::MM_MUL;
         bytes_mixed = key_bytes;
      end
      hash_state = h;
      if (!last) begin
         key_open = 1'b1;
         return;
      end
      key_open = 1'b0;
      h ^= h >> 13;
      h = h * hsk_pkg::MM_MUL;
      h ^= h >> 15;
      r.kind = hsk_pkg::KIND_ADD;
      r.index = h[IDX_BITS-1:0];
      val = h >> IDX_BITS;
      rank = (val == 0) ? 33 - IDX_BITS : 33 - IDX_BITS - bit_count_len(val);
      if (rank > rank_copy[r.index]) begin
         rank_copy[r.index] = rank[4:0];
         r.raised = 1'b1;
      end
      pending_results.push_back(r);
   endtask

   task automatic send_item(input logic func, input logic [31:0] word,
                            input logic [15:0] klen, input logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_key_word <= word;
      req_key_length <= klen;
      req_last_word <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sketch(func, word, klen, last);
   endtask

   task automatic send_key(input int unsigned nbytes, input int extra_words,
                           input bit early_stop);
      int words;
      words = (nbytes + 3) / 4 + extra_words;
      if (early_stop && words > 1) words = $urandom_range(1, words - 1);
      if (words == 0) words = 1;
      for (int w = 0; w < words; w++)
         send_item(hsk_pkg::FUNC_ADD, $urandom,
                   (w == 0) ? nbytes[15:0] : 16'($urandom), w == words - 1);
   endtask

   task automatic test_directed_keys();
      send_key(0, 0, 0);
      send_key(1, 0, 0);
      send_key(2, 0, 0);
      send_key(3, 0, 0);
      send_key(4, 0, 0);
      send_key(7, 0, 0);
      send_item(hsk_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'd4, 1'b1);
      send_item(hsk_pkg::FUNC_ADD, 32'h0000_0000, 16'd4, 1'b1);
      send_key(5, 2, 0);
      send_key(12, 0, 1);
      send_item(hsk_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      send_item(hsk_pkg::FUNC_ADD, 32'h0000_0000, 16'h0000, 1'b1);
      send_item(hsk_pkg::FUNC_ADD, 32'hA5A5_A5A5, 16'h5A5A, 1'b1);
   endtask

   task automatic test_count_empty_and_mid_key();
      send_item(hsk_pkg::FUNC_COUNT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_item(hsk_pkg::FUNC_ADD, $urandom, 16'd9, 1'b0);
      send_item(hsk_pkg::FUNC_COUNT, $urandom, 16'($urandom), 1'b0);
      send_item(hsk_pkg::FUNC_ADD, $urandom, 16'd0, 1'b0);
      send_item(hsk_pkg::FUNC_ADD, $urandom, 16'd0, 1'b1);
   endtask

   task automatic test_random_traffic(input int items);
      int sent;
      int pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            send_item(hsk_pkg::FUNC_COUNT, $urandom, 16'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 80) begin
            send_key($urandom_range(0, 16), 0, 0);
            sent += 3;
         end else if (pick < 90) begin
            send_key($urandom_range(0, 12), $urandom_range(0, 2), $urandom_range(0, 1));
            sent += 3;
         end else begin
            send_item(hsk_pkg::FUNC_ADD, $urandom, 16'($urandom), 1'($urandom));
            sent++;
         end
      end
      send_item(hsk_pkg::FUNC_COUNT, $urandom, 16'($urandom), 1'b0);
   endtask

   task automatic test_large_count();
      // 300 random four-byte keys fill a small share of the registers before a count.
      for (int i = 0; i < 300; i++) send_item(hsk_pkg::FUNC_ADD, $urandom, 16'd4, 1'b1);
      send_item(hsk_pkg::FUNC_COUNT, 32'd0, 16'd0, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sketch_result_type e;
            if (pending_results.size() == 0) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind=%0d index=%0d est=%0d",
                           rsp_result_kind, rsp_register_index, rsp_estimate);
            end else begin
               e = pending_results.pop_front();
               if (e.kind !== rsp_result_kind || e.raised !== rsp_register_raised ||
                   e.index !== rsp_register_index || e.estimate !== rsp_estimate) begin
                  failed = 1'b1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp k=%0d r=%0d i=%0d e=%0d got k=%0d r=%0d i=%0d e=%0d",
                              e.kind, e.raised, e.index, e.estimate, rsp_result_kind,
                              rsp_register_raised, rsp_register_index, rsp_estimate);
               end
            end
            stall_left = $urandom_range(0, 3);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_REGS; i++) rank_copy[i] = '0;
      hash_state = '0;
      bytes_mixed = '0;
      key_bytes = '0;
      key_open = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_keys();
      test_count_empty_and_mid_key();
      test_random_traffic(1100);
      test_large_count();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/hsk_pkg.sv
rtl/hsk_ram.sv
rtl/hsk_queue.sv
rtl/hsk_front.sv
rtl/hsk_back.sv
rtl/hyperloglog_sketch_core.sv
rtl/hsk_checker.sv
tb/hyperloglog_sketch_core_test.sv
